@@ src/hece_pkg.sv @@
// ----------------------------------------------------------------------------
// hece_pkg: shared types and byte generation for the code point encoder
// Holds the format modes, the item kinds passed from front to back and the
// function that forms one output byte of a classified item.
// ----------------------------------------------------------------------------
package hece_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 4;

    typedef enum logic [1:0] {
        MODE_VERBATIM,
        MODE_UTF8,
        MODE_HTML_CONTENT,
        MODE_HTML_OTHER
    } mode_t;

    typedef enum logic [2:0] {
        KIND_VERBATIM,
        KIND_UTF8,
        KIND_CHAR,
        KIND_LT,
        KIND_GT,
        KIND_AMP,
        KIND_HEX
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [LEN_W-1:0]  len;   // total byte count, 1 to 10
        logic [CP_W-1:0]   cp;
    } desc_t;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_0    = 8'h30;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = CH_0 + {4'd0, nib};
        end else begin
            res = CH_A + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

    function automatic logic [3:0] nibble_at(input logic [CP_W-1:0] cp, input logic [2:0] sel);
        logic [3:0] res;
        case (sel)
            3'd0:    res = cp[3:0];
            3'd1:    res = cp[7:4];
            3'd2:    res = cp[11:8];
            3'd3:    res = cp[15:12];
            3'd4:    res = cp[19:16];
            3'd5:    res = {3'd0, cp[20]};
            default: res = 4'd0;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] gen_byte(input desc_t d, input logic [LEN_W-1:0] idx);
        logic [7:0]       res;
        logic [LEN_W-1:0] nsel;
        res  = 8'h00;
        nsel = d.len - 4'd2 - idx;   // nibble index, counted from the low end
        case (d.kind)
            KIND_VERBATIM: begin
                case (idx)
                    4'd0:    res = d.cp[7:0];
                    4'd1:    res = d.cp[15:8];
                    4'd2:    res = {3'd0, d.cp[20:16]};
                    default: res = 8'h00;
                endcase
            end
            KIND_UTF8: begin
                case (d.len)
                    4'd1: res = d.cp[7:0];
                    4'd2: begin
                        res = (idx == 4'd0) ? {3'b110, d.cp[10:6]} : {2'b10, d.cp[5:0]};
                    end
                    4'd3: begin
                        case (idx)
                            4'd0:    res = {4'b1110, d.cp[15:12]};
                            4'd1:    res = {2'b10, d.cp[11:6]};
                            default: res = {2'b10, d.cp[5:0]};
                        endcase
                    end
                    default: begin
                        case (idx)
                            4'd0:    res = {5'b11110, d.cp[20:18]};
                            4'd1:    res = {2'b10, d.cp[17:12]};
                            4'd2:    res = {2'b10, d.cp[11:6]};
                            default: res = {2'b10, d.cp[5:0]};
                        endcase
                    end
                endcase
            end
            KIND_CHAR: res = d.cp[7:0];
            KIND_LT, KIND_GT: begin
                case (idx)
                    4'd0:    res = CH_AMP;
                    4'd1:    res = (d.kind == KIND_LT) ? CH_L : CH_G;
                    4'd2:    res = CH_T;
                    default: res = CH_SEMI;
                endcase
            end
            KIND_AMP: begin
                case (idx)
                    4'd0:    res = CH_AMP;
                    4'd1:    res = CH_A;
                    4'd2:    res = CH_M;
                    4'd3:    res = CH_P;
                    default: res = CH_SEMI;
                endcase
            end
            KIND_HEX: begin
                if (idx == 4'd0) begin
                    res = CH_AMP;
                end else if (idx == 4'd1) begin
                    res = CH_HASH;
                end else if (idx == 4'd2) begin
                    res = CH_X;
                end else if (idx == d.len - 4'd1) begin
                    res = CH_SEMI;
                end else begin
                    res = hex_char(nibble_at(d.cp, nsel[2:0]));
                end
            end
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

@@ src/hece_front.sv @@
// ----------------------------------------------------------------------------
// hece_front: input classifier
// Takes code points from the input channel, decides kind and byte count
// under the current mode and pushes the result into the queue.
// ----------------------------------------------------------------------------
module hece_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hece_pkg::CP_W-1:0]     code_point,
    input  hece_pkg::mode_t               mode,
    input  logic                          q_full,
    output logic                          q_push,
    output hece_pkg::desc_t               q_desc
);

    logic [hece_pkg::LEN_W-1:0] ndig;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // significant hex digits, at least one
    always_comb begin
        if (code_point[20]) begin
            ndig = 4'd6;
        end else if (code_point[19:16] != 4'd0) begin
            ndig = 4'd5;
        end else if (code_point[15:12] != 4'd0) begin
            ndig = 4'd4;
        end else if (code_point[11:8] != 4'd0) begin
            ndig = 4'd3;
        end else if (code_point[7:4] != 4'd0) begin
            ndig = 4'd2;
        end else begin
            ndig = 4'd1;
        end
    end

    always_comb begin
        q_desc.cp   = code_point;
        q_desc.kind = hece_pkg::KIND_CHAR;
        q_desc.len  = 4'd1;
        case (mode)
            hece_pkg::MODE_VERBATIM: begin
                q_desc.kind = hece_pkg::KIND_VERBATIM;
                q_desc.len  = 4'd4;
            end
            hece_pkg::MODE_UTF8: begin
                q_desc.kind = hece_pkg::KIND_UTF8;
                if (code_point < 21'h80) begin
                    q_desc.len = 4'd1;
                end else if (code_point < 21'h800) begin
                    q_desc.len = 4'd2;
                end else if (code_point < 21'h10000) begin
                    q_desc.len = 4'd3;
                end else begin
                    q_desc.len = 4'd4;
                end
            end
            hece_pkg::MODE_HTML_CONTENT, hece_pkg::MODE_HTML_OTHER: begin
                if (code_point[20:7] != 14'd0) begin
                    q_desc.kind = hece_pkg::KIND_HEX;
                    q_desc.len  = ndig + 4'd4;
                end else if (code_point[7:0] == hece_pkg::CH_AMP) begin
                    q_desc.kind = hece_pkg::KIND_AMP;
                    q_desc.len  = 4'd5;
                end else if (mode == hece_pkg::MODE_HTML_CONTENT &&
                             code_point[7:0] == hece_pkg::CH_LT) begin
                    q_desc.kind = hece_pkg::KIND_LT;
                    q_desc.len  = 4'd4;
                end else if (mode == hece_pkg::MODE_HTML_CONTENT &&
                             code_point[7:0] == hece_pkg::CH_GT) begin
                    q_desc.kind = hece_pkg::KIND_GT;
                    q_desc.len  = 4'd4;
                end
            end
            default: begin
                q_desc.kind = hece_pkg::KIND_CHAR;
                q_desc.len  = 4'd1;
            end
        endcase
    end

endmodule

@@ src/hece_queue.sv @@
// ----------------------------------------------------------------------------
// hece_queue: descriptor queue
// Small register queue between classifier and byte sequencer.
// ----------------------------------------------------------------------------
module hece_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hece_pkg::desc_t  push_desc,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output hece_pkg::desc_t  head_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hece_pkg::desc_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_desc = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ src/hece_back.sv @@
// ----------------------------------------------------------------------------
// hece_back: byte sequencer
// Walks the head descriptor one byte per cycle, while m_tready allows, into
// the output register and pops it as its last byte is loaded.
// ----------------------------------------------------------------------------
module hece_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  hece_pkg::desc_t  q_desc,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       out_byte,
    output logic             last_byte
);

    logic [hece_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       load, is_last;

    assign load      = !m_tvalid_reg || m_tready;
    assign is_last   = (idx_reg == q_desc.len - 4'd1);
    assign q_pop     = load && q_valid && is_last;
    assign m_tvalid  = m_tvalid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        if (load) begin
            m_tvalid_next = q_valid;
            if (q_valid) begin
                byte_next = hece_pkg::gen_byte(q_desc, idx_reg);
                last_next = is_last;
                idx_next  = is_last ? '0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> idx_reg == '0)
        else $error("byte index not at start with empty queue");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> idx_reg < q_desc.len)
        else $error("byte index past item length");

    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_tvalid_reg && last_reg)
        else $error("pop without a last byte presented");

endmodule

@@ src/html_escape_code_point_encoder.sv @@
// ----------------------------------------------------------------------------
// html_escape_code_point_encoder: code point to byte stream encoder
// Turns each code point into its verbatim, UTF-8 or HTML-escaped bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one code point per item in s_tdata[20:0].
//   m_* channel: one output byte per item in m_tdata[7:0]; m_tlast marks the
//   final byte of a code point. An item yields 1 to 10 bytes.
//   cfg_* channel: writes the 2-bit format mode (0 verbatim, 1 UTF-8,
//   2 HTML content escaping, 3 other HTML escaping); always ready. Write it
//   only while no item is in flight.
// Path: when the block is empty, an accepted item is written into the queue
//   and its first byte then goes into the output register that drives m_tvalid.
// Throughput: one output byte per cycle while m_tready is high; an item holds
//   the output until its 1 to 10 bytes are out; the byte sequencer is the
//   limit. The input keeps being taken while the queue has room.
// Reset: aresetn low clears the queue and the output valid flag and sets the
//   mode to verbatim.
// Stall: with m_tready low the output register holds its byte, the queue
//   fills up to QUEUE_DEPTH items and then s_tready drops.
// ----------------------------------------------------------------------------
module html_escape_code_point_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [20:0] code_point, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data    // [1:0] format_mode
);

    hece_pkg::mode_t mode_reg, mode_next;
    hece_pkg::desc_t push_desc, head_desc;
    logic            q_full, q_push, q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_valid) begin
            mode_next = hece_pkg::mode_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hece_pkg::MODE_VERBATIM;
        end else begin
            mode_reg <= mode_next;
        end
    end

    hece_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .code_point (s_tdata[20:0]),
        .mode       (mode_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_desc     (push_desc)
    );

    hece_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head_desc (head_desc)
    );

    hece_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_desc    (head_desc),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_byte  (m_tdata),
        .last_byte (m_tlast)
    );

endmodule

@@ verif/html_escape_code_point_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_escape_code_point_encoder_tb: self-checking bench for the encoder
// Runs phases in all four format modes. Each phase writes the mode while the
// block is idle, then streams boundary code points (first four phases only)
// and random ones. A local encoder computes the expected bytes of each
// accepted code point; every output byte is compared in order. Both sides
// idle at random and the output is held off long so the input backs up.
// ----------------------------------------------------------------------------
module html_escape_code_point_encoder_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 60;

    localparam logic [hece_pkg::CP_W-1:0] CP_LT  = 21'h00003C;
    localparam logic [hece_pkg::CP_W-1:0] CP_GT  = 21'h00003E;
    localparam logic [hece_pkg::CP_W-1:0] CP_AMP = 21'h000026;
    localparam logic [hece_pkg::CP_W-1:0] CP_MAX = 21'h1FFFFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // [20:0] code_point, [23:21] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;    // [1:0] format_mode

    logic [hece_pkg::CP_W-1:0] cp_pending[$];
    out_beat_t                 bytes_due[$];
    hece_pkg::mode_t           format_sel = hece_pkg::MODE_VERBATIM;
    int              error_count = 0;
    int              send_gap    = 0;
    int              hold_left   = 0;
    int              quiet_cycles = 0;
    bit              calm        = 1'b0;
    bit              stall_req   = 1'b0;

    html_escape_code_point_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // expected bytes of one code point in the given format
    function automatic void encode_expected(input hece_pkg::mode_t fmt,
                                            input logic [hece_pkg::CP_W-1:0] cp);
        logic [7:0]  seq[$];
        string       txt;
        string       hex_digits;
        logic [3:0]  nib;
        bit          started;
        hex_digits = "0123456789abcdef";
        txt        = "";
        started    = 1'b0;
        case (fmt)
            hece_pkg::MODE_VERBATIM: begin
                seq.push_back(cp[7:0]);
                seq.push_back(cp[15:8]);
                seq.push_back({3'b000, cp[20:16]});
                seq.push_back(8'h00);
            end
            hece_pkg::MODE_UTF8: begin
                if (cp < 21'h80) begin
                    seq.push_back(cp[7:0]);
                end else if (cp < 21'h800) begin
                    seq.push_back({3'b110, cp[10:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end else if (cp < 21'h10000) begin
                    seq.push_back({4'b1110, cp[15:12]});
                    seq.push_back({2'b10, cp[11:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end else begin
                    seq.push_back({5'b11110, cp[20:18]});
                    seq.push_back({2'b10, cp[17:12]});
                    seq.push_back({2'b10, cp[11:6]});
                    seq.push_back({2'b10, cp[5:0]});
                end
            end
            default: begin
                if (cp >= 21'h80) begin
                    txt = "&#x";
                    for (int sh = 20; sh >= 0; sh -= 4) begin
                        nib = 4'((cp >> sh) & 21'hF);
                        if (nib != 4'd0 || started || sh == 0) begin
                            started = 1'b1;
                            txt = {txt, hex_digits.substr(nib, nib)};
                        end
                    end
                    txt = {txt, ";"};
                end else if (cp == CP_LT && fmt == hece_pkg::MODE_HTML_CONTENT) begin
                    txt = "&lt;";
                end else if (cp == CP_GT && fmt == hece_pkg::MODE_HTML_CONTENT) begin
                    txt = "&gt;";
                end else if (cp == CP_AMP) begin
                    txt = "&amp;";
                end
                if (txt.len() == 0) begin
                    seq.push_back(cp[7:0]);
                end
                for (int i = 0; i < txt.len(); i++) begin
                    seq.push_back(txt[i]);
                end
            end
        endcase
        foreach (seq[k]) begin
            bytes_due.push_back('{data: seq[k], last: (k == seq.size() - 1)});
        end
    endfunction

    function automatic logic [hece_pkg::CP_W-1:0] pick_code_point();
        logic [hece_pkg::CP_W-1:0] cp;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 2))
                    0:       cp = CP_LT;
                    1:       cp = CP_GT;
                    default: cp = CP_AMP;
                endcase
            end
            1, 2:    cp = hece_pkg::CP_W'($urandom_range(0, 'h7F));
            3:       cp = hece_pkg::CP_W'($urandom_range('h80, 'h7FF));
            4:       cp = hece_pkg::CP_W'($urandom_range('h800, 'hFFFF));
            5:       cp = hece_pkg::CP_W'($urandom_range('hD800, 'hDFFF));
            6:       cp = hece_pkg::CP_W'($urandom_range('h10000, 'h10FFFF));
            7:       cp = hece_pkg::CP_W'($urandom_range('h110000, 'h1FFFFF));
            default: cp = hece_pkg::CP_W'($urandom());
        endcase
        return cp;
    endfunction

    // input side: offers queued code points, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_expected(format_sel, s_tdata[hece_pkg::CP_W-1:0]);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else if (cp_pending.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, cp_pending.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: checks each byte against the oldest expectation
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (bytes_due.size() == 0) begin
                    $error("unexpected item: out_byte %h last_byte %b", m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_byte: expected %b, actual %b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (cp_pending.size() != 0 || s_tvalid || bytes_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_format(input hece_pkg::mode_t fmt);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= fmt;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        format_sel = fmt;
    endtask

    task automatic run_phase(input hece_pkg::mode_t fmt, input int n_random,
                             input bit boundary, input bit squeeze);
        logic [hece_pkg::CP_W-1:0] corner_cps[$];
        wait_drained();
        set_format(fmt);
        if (boundary) begin
            case (fmt)
                hece_pkg::MODE_VERBATIM:
                    corner_cps = {21'h0, CP_MAX, 21'h155555, 21'h0AAAAA};
                hece_pkg::MODE_UTF8:
                    corner_cps = {21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF,
                                  21'hD800, 21'hDFFF, 21'h10000, 21'h10FFFF, CP_MAX};
                hece_pkg::MODE_HTML_CONTENT:
                    corner_cps = {CP_LT, CP_GT, CP_AMP, 21'h0, 21'h7F, 21'h80,
                                  21'h100000, CP_MAX};
                default:
                    corner_cps = {CP_LT, CP_GT, CP_AMP, 21'hFF};
            endcase
            foreach (corner_cps[i]) begin
                cp_pending.push_back(corner_cps[i]);
            end
        end
        repeat (n_random) cp_pending.push_back(pick_code_point());
        // hold the output off while the input keeps offering
        if (squeeze) begin
            @(negedge aclk);
            stall_req = 1'b1;
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        run_phase(hece_pkg::MODE_VERBATIM,     20, 1'b1, 1'b0);
        run_phase(hece_pkg::MODE_UTF8,         20, 1'b1, 1'b1);
        run_phase(hece_pkg::MODE_HTML_CONTENT, 20, 1'b1, 1'b0);
        run_phase(hece_pkg::MODE_HTML_OTHER,   20, 1'b1, 1'b0);
        run_phase(hece_pkg::MODE_HTML_CONTENT, 25, 1'b0, 1'b1);
        run_phase(hece_pkg::MODE_UTF8,         25, 1'b0, 1'b0);
        calm = 1'b1;
        run_phase(hece_pkg::MODE_HTML_OTHER,   25, 1'b0, 1'b0);
        repeat (8) @(posedge aclk);
        if (error_count == 0 && bytes_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
